>>> hdl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg - shared definitions of the priority interrupt controller
// Sizes, op codes, register map and the item/result/arbiter node types.
// ----------------------------------------------------------------------------
package pic_pkg;

   // Source count and field sizes
   localparam int NUM_SOURCES = 16;
   localparam int PRIO_FIELDS = 16;
   localparam int PRI_WIDTH   = 4;
   localparam int IDX_WIDTH   = 4;
   localparam int OP_WIDTH    = 2;
   localparam int CFG_WIDTH   = PRIO_FIELDS * PRI_WIDTH;

   // Arbiter tree shape
   localparam int TREE_LEVELS = $clog2(NUM_SOURCES);
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;

   // Op codes
   localparam logic [OP_WIDTH-1:0] OP_RAISE    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_WITHDRAW = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_POLL     = 2'd2;

   // Register map: 64-bit registers at byte address 8*i
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_DATA_WIDTH = 64;
   localparam logic [CSR_ADDR_WIDTH-CSR_INDEX_LSB-1:0] REG_SOURCE_PRIORITIES = 1'd0;

   typedef struct packed {
      logic [OP_WIDTH-1:0]  op;
      logic [IDX_WIDTH-1:0] source;
      logic [PRI_WIDTH-1:0] mask_level;
      logic                 block_all;
   } item_type;

   typedef struct packed {
      logic                 interrupt_pending;
      logic [IDX_WIDTH-1:0] winning_source;
      logic [PRI_WIDTH-1:0] winning_priority;
   } result_type;

   typedef struct packed {
      logic                 hit;
      logic [PRI_WIDTH-1:0] pri;
      logic [IDX_WIDTH-1:0] src;
   } node_type;

endpackage

>>> hdl/pic_req_if.sv
// ----------------------------------------------------------------------------
// pic_req_if - request channel of the priority interrupt controller
// Valid/ready channel carrying one update or poll beat.
// ----------------------------------------------------------------------------
interface pic_req_if;
   logic                           valid;
   logic                           ready;
   logic [pic_pkg::OP_WIDTH-1:0]   op;
   logic [pic_pkg::IDX_WIDTH-1:0]  source_id;
   logic [pic_pkg::PRI_WIDTH-1:0]  mask_level;
   logic                           block_all;

   modport source (output valid, op, source_id, mask_level, block_all, input ready);
   modport sink   (input valid, op, source_id, mask_level, block_all, output ready);
endinterface

>>> hdl/pic_rsp_if.sv
// ----------------------------------------------------------------------------
// pic_rsp_if - response channel of the priority interrupt controller
// Valid/ready channel carrying one arbitration result beat.
// ----------------------------------------------------------------------------
interface pic_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           interrupt_pending;
   logic [pic_pkg::IDX_WIDTH-1:0]  winning_source;
   logic [pic_pkg::PRI_WIDTH-1:0]  winning_priority;

   modport source (output valid, interrupt_pending, winning_source, winning_priority,
                   input ready);
   modport sink   (input valid, interrupt_pending, winning_source, winning_priority,
                   output ready);
endinterface

>>> hdl/pic_csr.sv
// ----------------------------------------------------------------------------
// pic_csr - configuration registers
// APB-style slave holding the per-source priority levels.
// ----------------------------------------------------------------------------
module pic_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pic_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pic_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pic_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready,
   output logic [pic_pkg::CFG_WIDTH-1:0]       priorities
);

   logic [pic_pkg::CSR_ADDR_WIDTH-pic_pkg::CSR_INDEX_LSB-1:0] reg_index;
   logic                                                      write_en;
   logic [pic_pkg::CFG_WIDTH-1:0]                             priorities_ff;
   logic [pic_pkg::CFG_WIDTH-1:0]                             priorities_in;

   assign reg_index  = csr_paddr[pic_pkg::CSR_ADDR_WIDTH-1:pic_pkg::CSR_INDEX_LSB];
   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Take the write data in the access phase
   always_comb begin
      priorities_in = priorities_ff;
      if (write_en && reg_index == pic_pkg::REG_SOURCE_PRIORITIES) begin
         priorities_in = csr_pwdata[pic_pkg::CFG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         priorities_ff <= '0;
      end else begin
         priorities_ff <= priorities_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         pic_pkg::REG_SOURCE_PRIORITIES: csr_prdata = priorities_ff;
         default:                        csr_prdata = '0;
      endcase
   end

   assign priorities = priorities_ff;

endmodule

>>> hdl/pic_arbiter.sv
// ----------------------------------------------------------------------------
// pic_arbiter - pending filter and priority tree
// Masks the requests and picks the highest level, lowest source on ties.
// ----------------------------------------------------------------------------
module pic_arbiter (
   input  logic [pic_pkg::NUM_SOURCES-1:0] requests,
   input  logic [pic_pkg::CFG_WIDTH-1:0]   priorities,
   input  logic [pic_pkg::PRI_WIDTH-1:0]   mask_level,
   input  logic                            block_all,
   output pic_pkg::result_type             result
);

   pic_pkg::node_type tree [0:pic_pkg::TREE_LEVELS][0:pic_pkg::TREE_LEAVES-1];

   always_comb begin
      logic [pic_pkg::PRI_WIDTH-1:0] pri;
      pic_pkg::node_type             left;
      pic_pkg::node_type             right;
      for (int lv = 0; lv <= pic_pkg::TREE_LEVELS; lv++) begin
         for (int n = 0; n < pic_pkg::TREE_LEAVES; n++) begin
            tree[lv][n] = '0;
         end
      end

      // Leaves: a source is a candidate when requested, above the mask, not blocked
      for (int k = 0; k < pic_pkg::NUM_SOURCES; k++) begin
         pri = '0;
         if (k < pic_pkg::PRIO_FIELDS) begin
            pri = priorities[pic_pkg::PRI_WIDTH*k +: pic_pkg::PRI_WIDTH];
         end
         if (requests[k] && pri > mask_level && !block_all) begin
            tree[0][k].hit = 1'b1;
            tree[0][k].pri = pri;
            tree[0][k].src = pic_pkg::IDX_WIDTH'(k);
         end
      end

      // Pairwise merge; the left (lower numbered) side keeps ties
      for (int lv = 0; lv < pic_pkg::TREE_LEVELS; lv++) begin
         for (int n = 0; n < (pic_pkg::TREE_LEAVES >> (lv + 1)); n++) begin
            left  = tree[lv][2*n];
            right = tree[lv][2*n+1];
            if (right.hit && (!left.hit || right.pri > left.pri)) begin
               tree[lv+1][n] = right;
            end else begin
               tree[lv+1][n] = left;
            end
         end
      end
   end

   // Report zeros when nothing is pending
   always_comb begin
      result = '0;
      if (tree[pic_pkg::TREE_LEVELS][0].hit) begin
         result.interrupt_pending = 1'b1;
         result.winning_source    = tree[pic_pkg::TREE_LEVELS][0].src;
         result.winning_priority  = tree[pic_pkg::TREE_LEVELS][0].pri;
      end
   end

endmodule

>>> hdl/priority_interrupt_controller_top.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller_top - prioritized interrupt controller
// Request bit store, one-item input stage and registered arbitration result.
// ----------------------------------------------------------------------------
// Each request beat raises or withdraws one source's request bit, or only
// polls, and returns exactly one response beat naming the highest-priority
// pending source (lowest number on ties) under the beat's mask level and
// block flag. The block takes one beat per cycle while the response side
// is not stalled: a beat is captured in the input register at the
// accepting edge, then the request-bit update and the 16-way priority tree
// settle combinationally into the response register as the beat advances,
// and the response beat is driven from that register.
// Backpressure on the response side stalls the input register. Source
// priorities come from the 64-bit register at address 0 and must be written
// only while no beat is in flight.
// ----------------------------------------------------------------------------
module priority_interrupt_controller_top (
   input  logic                                clock,
   input  logic                                reset,
   pic_req_if.sink                             req_chan,
   pic_rsp_if.source                           rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pic_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [pic_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [pic_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                csr_pready
);

   logic [pic_pkg::CFG_WIDTH-1:0]   priorities;
   logic                            s1_valid_ff, s1_valid_in;
   pic_pkg::item_type               s1_item_ff, s1_item_in;
   logic                            s1_advance;
   logic [pic_pkg::NUM_SOURCES-1:0] request_ff, request_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pic_pkg::result_type             rsp_ff, rsp_in;
   pic_pkg::result_type             arb_result;

   pic_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .priorities  (priorities)
   );

   // Move the input beat on when the response register is free or draining
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (req_chan.ready) begin
         s1_valid_in           = req_chan.valid;
         s1_item_in.op         = req_chan.op;
         s1_item_in.source     = req_chan.source_id;
         s1_item_in.mask_level = req_chan.mask_level;
         s1_item_in.block_all  = req_chan.block_all;
      end
   end

   // Apply raise/withdraw of the advancing beat; other codes leave bits alone
   always_comb begin
      request_in = request_ff;
      if (s1_advance) begin
         for (int k = 0; k < pic_pkg::NUM_SOURCES; k++) begin
            if (int'(s1_item_ff.source) == k) begin
               if (s1_item_ff.op == pic_pkg::OP_RAISE) begin
                  request_in[k] = 1'b1;
               end else if (s1_item_ff.op == pic_pkg::OP_WITHDRAW) begin
                  request_in[k] = 1'b0;
               end
            end
         end
      end
   end

   // Arbitrate over the updated request bits
   pic_arbiter u_arbiter (
      .requests   (request_in),
      .priorities (priorities),
      .mask_level (s1_item_ff.mask_level),
      .block_all  (s1_item_ff.block_all),
      .result     (arb_result)
   );

   // Response register: load on advance, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = arb_result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         request_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         request_ff   <= request_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.interrupt_pending = rsp_ff.interrupt_pending;
   assign rsp_chan.winning_source    = rsp_ff.winning_source;
   assign rsp_chan.winning_priority  = rsp_ff.winning_priority;

   // A raise leaves the source's request bit set
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_item_ff.op == pic_pkg::OP_RAISE)
      |=> request_ff[$past(s1_item_ff.source)])
      else $error("raised request bit not set");

   // A reported winner is always above the beat's mask level
   assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (!rsp_ff.interrupt_pending ||
                      rsp_ff.winning_priority > $past(s1_item_ff.mask_level)))
      else $error("winner not above mask level");

   // A blocked beat never reports a pending interrupt
   assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_item_ff.block_all) |=> !rsp_ff.interrupt_pending)
      else $error("pending reported while blocked");

   // Input stalls only when both stages are full and the response is not taken
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready))
      else $error("input stalled without backpressure");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the priority interrupt controller
// Sends raise, withdraw and poll beats under several priority settings and
// idling mixes. Every response beat is checked against a behavioral model of
// the request bits and the priority arbitration.
// ----------------------------------------------------------------------------
module tb_top;

   // The op code left unused by the package; the block treats it as a poll
   localparam logic [pic_pkg::OP_WIDTH-1:0] OP_SPARE = 2'd3;
   localparam logic [pic_pkg::CSR_ADDR_WIDTH-1:0] PRIO_ADDR =
      pic_pkg::CSR_ADDR_WIDTH'(pic_pkg::REG_SOURCE_PRIORITIES) << pic_pkg::CSR_INDEX_LSB;
   localparam logic [pic_pkg::CFG_WIDTH-1:0] DIRECTED_LEVELS = 64'hF294_6A85_CB1F_0773;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_BEATS    = 69;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [pic_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [pic_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [pic_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   pic_req_if req_bus ();
   pic_rsp_if rsp_bus ();

   priority_interrupt_controller_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus.sink),
      .rsp_chan    (rsp_bus.source),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Model state: raised requests and the configured priority levels
   logic [pic_pkg::NUM_SOURCES-1:0] raised_sources  = '0;
   logic [pic_pkg::CFG_WIDTH-1:0]   priority_levels = '0;
   pic_pkg::result_type             expected_winners[$];
   int                              error_count   = 0;
   int                              send_idle_pct = 0;
   int                              stall_pct     = 0;
   int                              quiet_cycles  = 0;

   // Apply one beat to the request bits, then pick the pending winner
   function automatic pic_pkg::result_type arbitrate(pic_pkg::item_type beat);
      pic_pkg::result_type           win;
      logic [pic_pkg::PRI_WIDTH-1:0] level;
      win = '0;
      if (beat.op == pic_pkg::OP_RAISE) begin
         raised_sources[beat.source] = 1'b1;
      end else if (beat.op == pic_pkg::OP_WITHDRAW) begin
         raised_sources[beat.source] = 1'b0;
      end
      if (!beat.block_all) begin
         for (int k = 0; k < pic_pkg::NUM_SOURCES; k++) begin
            level = priority_levels[k*pic_pkg::PRI_WIDTH +: pic_pkg::PRI_WIDTH];
            if (raised_sources[k] && level > beat.mask_level &&
                (!win.interrupt_pending || level > win.winning_priority)) begin
               win.interrupt_pending = 1'b1;
               win.winning_source    = k[pic_pkg::IDX_WIDTH-1:0];
               win.winning_priority  = level;
            end
         end
      end
      return win;
   endfunction

   // Predict a winner for every accepted request beat
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         expected_winners.push_back(arbitrate(pic_pkg::item_type'{op: req_bus.op,
            source: req_bus.source_id, mask_level: req_bus.mask_level,
            block_all: req_bus.block_all}));
      end
   end

   // Check every accepted response beat against the oldest prediction
   always @(posedge clock) begin
      pic_pkg::result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_winners.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response beat pending=%0d source=%0d priority=%0d",
                     $time, rsp_bus.interrupt_pending, rsp_bus.winning_source,
                     rsp_bus.winning_priority);
         end else begin
            want = expected_winners.pop_front();
            if (rsp_bus.interrupt_pending !== want.interrupt_pending) begin
               error_count++;
               $display("%0t: interrupt_pending expected %0d got %0d", $time,
                        want.interrupt_pending, rsp_bus.interrupt_pending);
            end
            if (rsp_bus.winning_source !== want.winning_source) begin
               error_count++;
               $display("%0t: winning_source expected %0d got %0d", $time,
                        want.winning_source, rsp_bus.winning_source);
            end
            if (rsp_bus.winning_priority !== want.winning_priority) begin
               error_count++;
               $display("%0t: winning_priority expected %0d got %0d", $time,
                        want.winning_priority, rsp_bus.winning_priority);
            end
         end
      end
   end

   // Stall the response side at the current rate
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request beat, idling first at the current rate, until accepted
   task automatic send_beat(logic [pic_pkg::OP_WIDTH-1:0] op,
                            logic [pic_pkg::IDX_WIDTH-1:0] src,
                            logic [pic_pkg::PRI_WIDTH-1:0] mask, logic blk);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= op;
      req_bus.source_id  <= src;
      req_bus.mask_level <= mask;
      req_bus.block_all  <= blk;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and hold until every predicted response has arrived
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_winners.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the priority register, then read it back
   task automatic set_priorities(logic [pic_pkg::CFG_WIDTH-1:0] levels);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PRIO_ADDR;
      csr_pwdata  <= levels;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      priority_levels = levels;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== levels) begin
         error_count++;
         $display("%0t: priority readback expected %h got %h", $time, levels, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [pic_pkg::CFG_WIDTH-1:0] random_levels(int style);
      logic [pic_pkg::CFG_WIDTH-1:0] levels;
      for (int k = 0; k < pic_pkg::PRIO_FIELDS; k++) begin
         case (style)
            // Few distinct levels, many ties
            1: levels[k*pic_pkg::PRI_WIDTH +: pic_pkg::PRI_WIDTH] =
                  ($urandom_range(2) == 0) ? '0 :
                  pic_pkg::PRI_WIDTH'($urandom_range(15, 14));
            // Low levels, so most masks shut everything out
            2: levels[k*pic_pkg::PRI_WIDTH +: pic_pkg::PRI_WIDTH] =
                  pic_pkg::PRI_WIDTH'($urandom_range(3));
            default: levels[k*pic_pkg::PRI_WIDTH +: pic_pkg::PRI_WIDTH] =
                  pic_pkg::PRI_WIDTH'($urandom);
         endcase
      end
      return levels;
   endfunction

   // Walk through ties, masking, blocking, the spare op and stale requests
   task automatic test_directed_cases();
      send_idle_pct = 0;
      stall_pct     = 0;
      set_priorities(DIRECTED_LEVELS);
      send_beat(pic_pkg::OP_POLL,     4'd0,  4'd0,  1'b0);  // nothing raised after reset
      send_beat(pic_pkg::OP_RAISE,    4'd3,  4'd0,  1'b0);  // priority zero never pends
      send_beat(pic_pkg::OP_RAISE,    4'd1,  4'd0,  1'b0);
      send_beat(pic_pkg::OP_RAISE,    4'd2,  4'd0,  1'b0);  // tie at 7, lower number wins
      send_beat(pic_pkg::OP_RAISE,    4'd0,  4'd15, 1'b0);  // top mask shuts all out
      send_beat(pic_pkg::OP_WITHDRAW, 4'd1,  4'd6,  1'b0);
      send_beat(pic_pkg::OP_POLL,     4'd9,  4'd7,  1'b0);  // level equal to mask is not taken
      send_beat(pic_pkg::OP_RAISE,    4'd4,  4'd0,  1'b1);  // blocked
      send_beat(pic_pkg::OP_POLL,     4'd0,  4'd14, 1'b0);  // blocked request still held
      send_beat(pic_pkg::OP_RAISE,    4'd15, 4'd0,  1'b0);  // tie at 15
      send_beat(pic_pkg::OP_WITHDRAW, 4'd4,  4'd0,  1'b0);
      send_beat(OP_SPARE,             4'd15, 4'd0,  1'b0);  // spare op changes nothing
      send_beat(pic_pkg::OP_WITHDRAW, 4'd15, 4'd0,  1'b0);
      send_beat(pic_pkg::OP_WITHDRAW, 4'd2,  4'd0,  1'b0);  // source 0 wins now
      send_beat(pic_pkg::OP_WITHDRAW, 4'd0,  4'd0,  1'b0);
      send_beat(pic_pkg::OP_RAISE,    4'd5,  4'd0,  1'b0);
      send_beat(pic_pkg::OP_POLL,     4'd5,  4'd1,  1'b0);
      send_beat(pic_pkg::OP_WITHDRAW, 4'd3,  4'd0,  1'b1);
      wait_idle();
      set_priorities('1);
      send_beat(pic_pkg::OP_POLL,     4'd0,  4'd14, 1'b0);
      send_beat(pic_pkg::OP_RAISE,    4'd0,  4'd0,  1'b0);
      send_beat(pic_pkg::OP_RAISE,    4'd15, 4'd15, 1'b0);
      send_beat(pic_pkg::OP_WITHDRAW, 4'd0,  4'd14, 1'b0);
      wait_idle();
   endtask

   // Random beats across priority settings and idling mixes
   task automatic test_random_traffic();
      logic [pic_pkg::OP_WIDTH-1:0] op;
      int                           pick;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 7; stall_pct = 7; end
         endcase
         case (phase)
            0: set_priorities('1);
            1: set_priorities('0);
            default: set_priorities(random_levels(phase % 3));
         endcase
         repeat (PHASE_BEATS) begin
            pick = $urandom_range(99);
            op = (pick < 45) ? pic_pkg::OP_RAISE : (pick < 80) ? pic_pkg::OP_WITHDRAW :
                 (pick < 94) ? pic_pkg::OP_POLL : OP_SPARE;
            send_beat(op, pic_pkg::IDX_WIDTH'($urandom_range(pic_pkg::NUM_SOURCES - 1)),
                      pic_pkg::PRI_WIDTH'($urandom), $urandom_range(9) == 0);
         end
         wait_idle();
      end
   endtask

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.op         = pic_pkg::OP_POLL;
      req_bus.source_id  = '0;
      req_bus.mask_level = '0;
      req_bus.block_all  = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> priority_interrupt_controller_top.f
hdl/pic_pkg.sv
hdl/pic_req_if.sv
hdl/pic_rsp_if.sv
hdl/pic_csr.sv
hdl/pic_arbiter.sv
hdl/priority_interrupt_controller_top.sv
tb/tb_top.sv
